// ===== src/bnta_pkg.sv =====
// ----------------------------------------------------------------------------
// bnta_pkg: shared constants and tables of the battery and thermistor averager
// Window and scale constants, fixed-point constants of the Beta equation,
// operand widths of the serial arithmetic units and the log2 fraction table.
// ----------------------------------------------------------------------------
package bnta_pkg;

   // Averaging window and converter scale.
   localparam int WINDOW         = 10;
   localparam int ADC_FULL_SCALE = 4096;
   localparam int TSUM_FULL      = ADC_FULL_SCALE * WINDOW;

   localparam int SAMPLE_W  = 12;
   localparam int SUM_W     = 16;
   localparam int COUNT_W   = 4;
   localparam int PERCENT_W = 7;
   localparam int TEMP_W    = 13;

   localparam logic [COUNT_W-1:0] COUNT_LAST  = COUNT_W'(WINDOW - 1);
   localparam logic [16:0]        WINDOW_MULT = 17'(WINDOW);

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;
   localparam logic [CSR_INDEX_W-1:0] REG_SERIES  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_NOMINAL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BETA    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_EMPTY   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FULL    = 3'd4;

   // Serial unit widths.
   localparam int LOG_ARG_W = 20;
   localparam int LOG_POS_W = 5;
   localparam int LOG_RES_W = 21;
   localparam int MUL_ARG_W = 22;
   localparam int PROD_W    = 45;
   localparam int DIV_NUM_W = 47;
   localparam int DIV_DEN_W = 36;
   localparam int DIV_CNT_W = 6;
   localparam int MUL_CNT_W = 5;

   // Beta equation constants: 2^40/298.15, ln2 in Q24 and the output offset.
   localparam logic [23:0]          LN2_Q24     = 24'd11629080;
   localparam logic [DIV_NUM_W-1:0] INV_T25_Q40 = 47'd3687780070;
   localparam logic [DIV_NUM_W-1:0] FIVE_2_44   = 47'd5 << 44;
   localparam int TEMP_MIN   = -880;
   localparam int TEMP_MAX   = 2400;
   localparam int OFFSET_NUM = 21812;

   // The numerator is biased by the lower limit so the quotient is never negative.
   localparam logic [14:0] OFFSET_BIASED = 15'(OFFSET_NUM + 5 * TEMP_MIN);
   localparam logic [DIV_NUM_W-1:0] U_LIMIT = FIVE_2_44 / 47'(OFFSET_BIASED);
   localparam logic [DIV_NUM_W-1:0] TEMP_SPAN = 47'(TEMP_MAX - TEMP_MIN);
   localparam logic [TEMP_W-1:0] TEMP_BIAS = 13'(-TEMP_MIN);
   localparam logic signed [TEMP_W-1:0] TEMP_MIN_CODE = 13'(TEMP_MIN);
   localparam logic signed [TEMP_W-1:0] TEMP_MAX_CODE = 13'(TEMP_MAX);

   localparam logic [PERCENT_W-1:0] PCT_FULL  = 7'd100;
   localparam logic [22:0]          PCT_SCALE = 23'd100;

   // log2(1 + i/32) in Q16 for i = 0..32.
   function automatic logic [16:0] log2_frac(input logic [5:0] idx);
      logic [16:0] val;
      case (idx)
         6'd0:  val = 17'd0;
         6'd1:  val = 17'd2909;
         6'd2:  val = 17'd5732;
         6'd3:  val = 17'd8473;
         6'd4:  val = 17'd11136;
         6'd5:  val = 17'd13727;
         6'd6:  val = 17'd16248;
         6'd7:  val = 17'd18704;
         6'd8:  val = 17'd21098;
         6'd9:  val = 17'd23433;
         6'd10: val = 17'd25711;
         6'd11: val = 17'd27936;
         6'd12: val = 17'd30109;
         6'd13: val = 17'd32234;
         6'd14: val = 17'd34312;
         6'd15: val = 17'd36346;
         6'd16: val = 17'd38336;
         6'd17: val = 17'd40286;
         6'd18: val = 17'd42196;
         6'd19: val = 17'd44068;
         6'd20: val = 17'd45904;
         6'd21: val = 17'd47705;
         6'd22: val = 17'd49472;
         6'd23: val = 17'd51207;
         6'd24: val = 17'd52911;
         6'd25: val = 17'd54584;
         6'd26: val = 17'd56229;
         6'd27: val = 17'd57845;
         6'd28: val = 17'd59434;
         6'd29: val = 17'd60997;
         6'd30: val = 17'd62534;
         6'd31: val = 17'd64047;
         6'd32: val = 17'd65536;
         default: val = 17'd0;
      endcase
      return val;
   endfunction

endpackage

// ===== src/bnta_log2.sv =====
// ----------------------------------------------------------------------------
// bnta_log2: serial base-2 logarithm in Q16
// Shifts the operand left one bit per cycle until the leading one reaches the
// top, then interpolates the fraction between two table entries.
// ----------------------------------------------------------------------------
module bnta_log2 import bnta_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [LOG_ARG_W-1:0] arg,
   output logic                 done,
   output logic [LOG_RES_W-1:0] result
);

   logic                 search_ff, search_in;
   logic                 calc_ff, calc_in;
   logic                 done_ff, done_in;
   logic [LOG_ARG_W-1:0] norm_ff, norm_in;
   logic [LOG_POS_W-1:0] pos_ff, pos_in;
   logic [16:0]          base_ff, base_in;
   logic [11:0]          step_ff, step_in;
   logic [10:0]          frac_ff, frac_in;
   logic [LOG_RES_W-1:0] result_ff, result_in;
   logic [4:0]           idx;
   logic [16:0]          tbl_lo, tbl_hi;
   logic [22:0]          interp;

   assign idx    = norm_ff[LOG_ARG_W-2 -: 5];
   assign tbl_lo = log2_frac({1'b0, idx});
   assign tbl_hi = log2_frac(6'({1'b0, idx} + 6'd1));
   assign interp = 23'(step_ff) * 23'(frac_ff);

   always_comb begin
      search_in = search_ff;
      calc_in   = 1'b0;
      done_in   = 1'b0;
      norm_in   = norm_ff;
      pos_in    = pos_ff;
      base_in   = base_ff;
      step_in   = step_ff;
      frac_in   = frac_ff;
      result_in = result_ff;
      if (go) begin
         norm_in   = arg;
         pos_in    = LOG_POS_W'(LOG_ARG_W - 1);
         search_in = 1'b1;
      end else if (search_ff) begin
         // Stop at the leading one; a position of zero also ends the search.
         if (norm_ff[LOG_ARG_W-1] || pos_ff == '0) begin
            search_in = 1'b0;
            calc_in   = 1'b1;
            base_in   = tbl_lo;
            step_in   = 12'(tbl_hi - tbl_lo);
            frac_in   = norm_ff[LOG_ARG_W-7 -: 11];
         end else begin
            norm_in = {norm_ff[LOG_ARG_W-2:0], 1'b0};
            pos_in  = pos_ff - 5'd1;
         end
      end else if (calc_ff) begin
         done_in   = 1'b1;
         result_in = LOG_RES_W'({pos_ff, 16'd0}) + LOG_RES_W'(base_ff)
                   + LOG_RES_W'(interp[22:11]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_ff <= 1'b0;
         calc_ff   <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         search_ff <= search_in;
         calc_ff   <= calc_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      norm_ff   <= norm_in;
      pos_ff    <= pos_in;
      base_ff   <= base_in;
      step_ff   <= step_in;
      frac_ff   <= frac_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== src/bnta_mul.sv =====
// ----------------------------------------------------------------------------
// bnta_mul: bit-serial multiply by ln2 in Q24
// Takes one operand bit per cycle, most significant first, and doubles and
// adds into the product register.
// ----------------------------------------------------------------------------
module bnta_mul import bnta_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [MUL_ARG_W-1:0] arg,
   output logic                 done,
   output logic [PROD_W-1:0]    product
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MUL_ARG_W-1:0] shreg_ff, shreg_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shreg_in = shreg_ff;
      acc_in   = acc_ff;
      if (go) begin
         busy_in  = 1'b1;
         cnt_in   = MUL_CNT_W'(MUL_ARG_W);
         shreg_in = arg;
         acc_in   = '0;
      end else if (busy_ff) begin
         acc_in   = {acc_ff[PROD_W-2:0], 1'b0}
                  + (shreg_ff[MUL_ARG_W-1] ? PROD_W'(LN2_Q24) : '0);
         shreg_in = {shreg_ff[MUL_ARG_W-2:0], 1'b0};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      shreg_ff <= shreg_in;
      acc_ff   <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== src/bnta_div.sv =====
// ----------------------------------------------------------------------------
// bnta_div: bit-serial restoring divider
// Brings in one dividend bit per cycle and produces one quotient bit per
// cycle; shared by the percent, Beta and temperature divisions.
// ----------------------------------------------------------------------------
module bnta_div import bnta_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [DIV_NUM_W-1:0] dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial, diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // The dividend register fills with quotient bits from the bottom.
         rem_in = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/battery_and_ntc_thermistor_averager.sv =====
// ----------------------------------------------------------------------------
// battery_and_ntc_thermistor_averager: windowed battery and NTC temperature
// Sums battery and thermistor samples over a window and converts the window
// averages to charge percent and temperature in 1/16 degree Celsius.
// ----------------------------------------------------------------------------
// Each request on the req_ channel carries one battery and one thermistor
// sample. Requests that do not close a window are taken and give no response.
// The request that closes a window of WINDOW samples starts the conversion;
// one response then appears on the rsp_ channel. The conversion uses the
// shared serial divider (up to three divisions), the serial log unit (for
// each of four operands) and the serial multiplier. req_ready is low while a
// conversion runs. A finished response waits in the output register while
// rsp_ready is low; new requests are still taken then, and only a second
// finished response waits for the first to leave.
// Reset clears the window sums and count, drops rsp_valid and loads the
// default configuration. The csr_ port writes a register when csr_we is high;
// the user must see that it is written only while no conversion is in
// progress, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module battery_and_ntc_thermistor_averager import bnta_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [SAMPLE_W-1:0]           req_battery_sample,
   input  logic [SAMPLE_W-1:0]           req_thermistor_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [PERCENT_W-1:0]          rsp_battery_percent,
   output logic signed [TEMP_W-1:0]      rsp_temperature_sixteenths,
   output logic                          rsp_temperature_out_of_range,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_PCT  = 4'd1;
   localparam logic [3:0] S_PDIV = 4'd2;
   localparam logic [3:0] S_TCHK = 4'd3;
   localparam logic [3:0] S_LOG  = 4'd4;
   localparam logic [3:0] S_MUL  = 4'd5;
   localparam logic [3:0] S_BDIV = 4'd6;
   localparam logic [3:0] S_UCHK = 4'd7;
   localparam logic [3:0] S_TDIV = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   localparam logic [1:0] OP_LAST = 2'd3;

   // Configuration registers.
   logic [19:0] series_ff;
   logic [19:0] nominal_ff;
   logic [13:0] beta_ff;
   logic [11:0] empty_ff;
   logic [11:0] full_ff;

   // Sequencer and window state.
   logic [3:0]                 state_ff, state_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic [SUM_W-1:0]           battery_sum_ff, battery_sum_in;
   logic [SUM_W-1:0]           thermistor_sum_ff, thermistor_sum_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       log_go_ff, log_go_in;
   logic                       mul_go_ff, mul_go_in;
   logic                       div_go_ff, div_go_in;

   // Working values of one conversion.
   logic [SUM_W-1:0]           bat_win_ff, bat_win_in;
   logic [SUM_W-1:0]           thm_win_ff, thm_win_in;
   logic [PERCENT_W-1:0]       pct_ff, pct_in;
   logic signed [TEMP_W-1:0]   temp_ff, temp_in;
   logic                       oor_ff, oor_in;
   logic signed [22:0]         lacc_ff, lacc_in;
   logic                       lneg_ff, lneg_in;
   logic [1:0]                 op_ff, op_in;
   logic [DIV_NUM_W-1:0]       u_ff, u_in;
   logic [LOG_ARG_W-1:0]       log_arg_ff, log_arg_in;
   logic [MUL_ARG_W-1:0]       mul_arg_ff, mul_arg_in;
   logic [DIV_NUM_W-1:0]       div_num_ff, div_num_in;
   logic [DIV_DEN_W-1:0]       div_den_ff, div_den_in;
   logic [PERCENT_W-1:0]       rsp_pct_ff, rsp_pct_in;
   logic signed [TEMP_W-1:0]   rsp_temp_ff, rsp_temp_in;
   logic                       rsp_oor_ff, rsp_oor_in;

   // Unit results.
   logic                       log_done;
   logic [LOG_RES_W-1:0]       log_res;
   logic                       mul_done;
   logic [PROD_W-1:0]          mul_prod;
   logic                       div_done;
   logic [DIV_NUM_W-1:0]       div_quo;

   // Datapath helpers.
   logic                       req_fire;
   logic [SUM_W-1:0]           bat_next, thm_next;
   logic [16:0]                empty_w, full_w, pct_den;
   logic [17:0]                pct_num;
   logic                       num_pos, num_ge;
   logic [22:0]                num100;
   logic [20:0]                thm_den;
   logic                       thm_over;
   logic [LOG_ARG_W-1:0]       log_pick;
   logic signed [22:0]         log_ext, lacc_next, lacc_mag;
   logic [DIV_NUM_W-1:0]       quot47, quot_signed, u_calc;
   logic [47:0]                u_scaled;
   logic [DIV_NUM_W-1:0]       tnum;
   logic [DIV_DEN_W-1:0]       tden;
   logic [13:0]                beta_eff;

   assign req_fire = req_valid && req_ready;
   assign bat_next = battery_sum_ff + SUM_W'(req_battery_sample);
   assign thm_next = thermistor_sum_ff + SUM_W'(req_thermistor_sample);

   assign empty_w = 17'(empty_ff) * WINDOW_MULT;
   assign full_w  = 17'(full_ff) * WINDOW_MULT;
   assign pct_den = full_w - empty_w;
   assign pct_num = 18'(bat_win_ff) - 18'(empty_w);
   assign num_pos = !pct_num[17] && (pct_num != '0);
   assign num_ge  = pct_num[16:0] >= pct_den;
   assign num100  = 23'(pct_num[15:0]) * PCT_SCALE;

   assign thm_over = 21'(thm_win_ff) >= 21'(TSUM_FULL);
   assign thm_den  = 21'(TSUM_FULL) - 21'(thm_win_ff);

   always_comb begin
      case (op_ff)
         2'd0:    log_pick = LOG_ARG_W'(thm_win_ff);
         2'd1:    log_pick = thm_den[LOG_ARG_W-1:0];
         default: log_pick = nominal_ff;
      endcase
   end

   // The first two logs add, the last two subtract.
   assign log_ext   = $signed({2'b00, log_res});
   assign lacc_next = op_ff[1] ? (lacc_ff - log_ext) : (lacc_ff + log_ext);
   assign lacc_mag  = lacc_next[22] ? -lacc_next : lacc_next;

   assign quot47      = {2'b00, div_quo[PROD_W-1:0]};
   assign quot_signed = lneg_ff ? (~quot47 + 47'd1) : quot47;
   assign u_calc      = INV_T25_Q40 + quot_signed;

   assign u_scaled = 48'(u_ff[32:0]) * 48'(OFFSET_BIASED);
   assign tnum     = FIVE_2_44 - u_scaled[DIV_NUM_W-1:0];
   assign tden     = DIV_DEN_W'({u_ff[32:0], 2'b00}) + DIV_DEN_W'(u_ff[32:0]);

   assign beta_eff = (beta_ff == '0) ? 14'd1 : beta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff  <= 20'd10000;
         nominal_ff <= 20'd30000;
         beta_ff    <= 14'd3950;
         empty_ff   <= 12'd2048;
         full_ff    <= 12'd2607;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SERIES:  series_ff  <= csr_wdata;
            REG_NOMINAL: nominal_ff <= csr_wdata;
            REG_BETA:    beta_ff    <= csr_wdata[13:0];
            REG_EMPTY:   empty_ff   <= csr_wdata[11:0];
            REG_FULL:    full_ff    <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      battery_sum_in    = battery_sum_ff;
      thermistor_sum_in = thermistor_sum_ff;
      rsp_valid_in      = rsp_valid_ff;
      log_go_in         = 1'b0;
      mul_go_in         = 1'b0;
      div_go_in         = 1'b0;
      bat_win_in        = bat_win_ff;
      thm_win_in        = thm_win_ff;
      pct_in            = pct_ff;
      temp_in           = temp_ff;
      oor_in            = oor_ff;
      lacc_in           = lacc_ff;
      lneg_in           = lneg_ff;
      op_in             = op_ff;
      u_in              = u_ff;
      log_arg_in        = log_arg_ff;
      mul_arg_in        = mul_arg_ff;
      div_num_in        = div_num_ff;
      div_den_in        = div_den_ff;
      rsp_pct_in        = rsp_pct_ff;
      rsp_temp_in       = rsp_temp_ff;
      rsp_oor_in        = rsp_oor_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (count_ff == COUNT_LAST) begin
                  bat_win_in        = bat_next;
                  thm_win_in        = thm_next;
                  battery_sum_in    = '0;
                  thermistor_sum_in = '0;
                  count_in          = '0;
                  state_in          = S_PCT;
               end else begin
                  battery_sum_in    = bat_next;
                  thermistor_sum_in = thm_next;
                  count_in          = count_ff + 1'b1;
               end
            end
         end
         S_PCT: begin
            state_in = S_TCHK;
            if (full_ff <= empty_ff) begin
               pct_in = (17'(bat_win_ff) >= full_w) ? PCT_FULL : '0;
            end else if (!num_pos) begin
               pct_in = '0;
            end else if (num_ge) begin
               pct_in = PCT_FULL;
            end else begin
               div_num_in = DIV_NUM_W'(num100);
               div_den_in = DIV_DEN_W'(pct_den);
               div_go_in  = 1'b1;
               state_in   = S_PDIV;
            end
         end
         S_PDIV: begin
            if (div_done) begin
               pct_in   = div_quo[PERCENT_W-1:0];
               state_in = S_TCHK;
            end
         end
         S_TCHK: begin
            if (thm_win_ff == '0 || series_ff == '0) begin
               temp_in  = TEMP_MAX_CODE;
               oor_in   = 1'b1;
               state_in = S_OUT;
            end else if (thm_over || nominal_ff == '0) begin
               temp_in  = TEMP_MIN_CODE;
               oor_in   = 1'b1;
               state_in = S_OUT;
            end else begin
               log_arg_in = series_ff;
               log_go_in  = 1'b1;
               op_in      = '0;
               lacc_in    = '0;
               state_in   = S_LOG;
            end
         end
         S_LOG: begin
            if (log_done) begin
               lacc_in = lacc_next;
               if (op_ff == OP_LAST) begin
                  mul_arg_in = lacc_mag[MUL_ARG_W-1:0];
                  lneg_in    = lacc_next[22];
                  mul_go_in  = 1'b1;
                  state_in   = S_MUL;
               end else begin
                  op_in      = op_ff + 1'b1;
                  log_arg_in = log_pick;
                  log_go_in  = 1'b1;
               end
            end
         end
         S_MUL: begin
            if (mul_done) begin
               div_num_in = DIV_NUM_W'(mul_prod);
               div_den_in = DIV_DEN_W'(beta_eff);
               div_go_in  = 1'b1;
               state_in   = S_BDIV;
            end
         end
         S_BDIV: begin
            if (div_done) begin
               u_in     = u_calc;
               state_in = S_UCHK;
            end
         end
         S_UCHK: begin
            if (u_ff[DIV_NUM_W-1] || u_ff == '0) begin
               temp_in  = TEMP_MAX_CODE;
               oor_in   = 1'b1;
               state_in = S_OUT;
            end else if (u_ff > U_LIMIT) begin
               // Inverse temperature this large means below the lower limit.
               temp_in  = TEMP_MIN_CODE;
               oor_in   = 1'b1;
               state_in = S_OUT;
            end else begin
               div_num_in = tnum;
               div_den_in = tden;
               div_go_in  = 1'b1;
               state_in   = S_TDIV;
            end
         end
         S_TDIV: begin
            if (div_done) begin
               if (div_quo > TEMP_SPAN) begin
                  temp_in = TEMP_MAX_CODE;
                  oor_in  = 1'b1;
               end else begin
                  temp_in = $signed(div_quo[TEMP_W-1:0] - TEMP_BIAS);
                  oor_in  = 1'b0;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_pct_in   = pct_ff;
               rsp_temp_in  = temp_ff;
               rsp_oor_in   = oor_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         count_ff          <= '0;
         battery_sum_ff    <= '0;
         thermistor_sum_ff <= '0;
         rsp_valid_ff      <= 1'b0;
         log_go_ff         <= 1'b0;
         mul_go_ff         <= 1'b0;
         div_go_ff         <= 1'b0;
      end else begin
         state_ff          <= state_in;
         count_ff          <= count_in;
         battery_sum_ff    <= battery_sum_in;
         thermistor_sum_ff <= thermistor_sum_in;
         rsp_valid_ff      <= rsp_valid_in;
         log_go_ff         <= log_go_in;
         mul_go_ff         <= mul_go_in;
         div_go_ff         <= div_go_in;
      end
   end

   always_ff @(posedge clock) begin
      bat_win_ff  <= bat_win_in;
      thm_win_ff  <= thm_win_in;
      pct_ff      <= pct_in;
      temp_ff     <= temp_in;
      oor_ff      <= oor_in;
      lacc_ff     <= lacc_in;
      lneg_ff     <= lneg_in;
      op_ff       <= op_in;
      u_ff        <= u_in;
      log_arg_ff  <= log_arg_in;
      mul_arg_ff  <= mul_arg_in;
      div_num_ff  <= div_num_in;
      div_den_ff  <= div_den_in;
      rsp_pct_ff  <= rsp_pct_in;
      rsp_temp_ff <= rsp_temp_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   bnta_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .go     (log_go_ff),
      .arg    (log_arg_ff),
      .done   (log_done),
      .result (log_res)
   );

   bnta_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (mul_go_ff),
      .arg     (mul_arg_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   bnta_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go_ff),
      .dividend (div_num_ff),
      .divisor  (div_den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_ready                    = (state_ff == S_IDLE);
   assign rsp_valid                    = rsp_valid_ff;
   assign rsp_battery_percent          = rsp_pct_ff;
   assign rsp_temperature_sixteenths   = rsp_temp_ff;
   assign rsp_temperature_out_of_range = rsp_oor_ff;

`ifndef SYNTH
   a_window_clear: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && count_ff == COUNT_LAST) |=>
      (count_ff == '0 && battery_sum_ff == '0 && thermistor_sum_ff == '0))
      else $error("window sums not cleared after the closing request");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) |=> $stable(count_ff))
      else $error("sample count moved without an accepted request");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_battery_percent <= PCT_FULL &&
      (rsp_temperature_out_of_range ||
      (rsp_temperature_sixteenths >= TEMP_MIN_CODE &&
       rsp_temperature_sixteenths <= TEMP_MAX_CODE))))
      else $error("response value outside its range");
`endif

endmodule
